[rtl/lae_pkg.sv]
// ----------------------------------------------------------------------------
// lae_pkg
// shared types and constants of the led envelope generator
// ----------------------------------------------------------------------------
package lae_pkg;

  localparam int unsigned TICK_W   = 10;
  localparam int unsigned LEVEL_W  = 8;
  localparam int unsigned PADDR_W  = 5;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [TICK_W-1:0]  OFFSET_LIMIT  = TICK_W'(1000);
  localparam logic [LEVEL_W-1:0] MAX_LEVEL_RST = LEVEL_W'(255);

  typedef enum logic [2:0] {
    REG_ATTACK  = 3'd0,
    REG_DECAY   = 3'd1,
    REG_RELEASE = 3'd2,
    REG_MIN     = 3'd3,
    REG_MAX     = 3'd4
  } reg_idx_t;

  typedef enum logic [1:0] {
    PH_IDLE    = 2'd0,
    PH_ATTACK  = 2'd1,
    PH_HOLD    = 2'd2,
    PH_RELEASE = 2'd3
  } phase_t;

  typedef struct packed {
    logic [TICK_W-1:0]  attack_ticks;
    logic [TICK_W-1:0]  decay_ticks;
    logic [TICK_W-1:0]  release_ticks;
    logic [LEVEL_W-1:0] min_level;
    logic [LEVEL_W-1:0] max_level;
  } env_cfg_t;

endpackage

[rtl/led_adsr_envelope.sv]
// ----------------------------------------------------------------------------
// led_adsr_envelope
// attack / hold / release brightness envelope for one led, one item per tick
// ----------------------------------------------------------------------------
//  channel  direction  handshake            payload
//  in       input      in_valid / in_stall  in_trigger
//  out      output     out_valid/out_stall  out_level, out_phase
//  cfg      input      apb write / read     five envelope registers
//
//  each item passes through these steps: the phase is picked at the accepting
//  edge, the bit-serial step divider works out the eight quotient bits, ST_DIV
//  sees the divider finish and ST_DONE loads the output register. the next
//  item is taken once the state is back in idle. one item is worked on at a
//  time; in_stall is high while it is in flight. a stalled result holds the
//  finishing step.
//  synchronous active-low reset restores register defaults, offset and level.
// ----------------------------------------------------------------------------
module led_adsr_envelope
  import lae_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_trigger,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [LEVEL_W-1:0] out_level,
  output logic [1:0]         out_phase,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [PADDR_W-1:0] cfg_paddr,
  input  logic [PDATA_W-1:0] cfg_pwdata,
  output logic [PDATA_W-1:0] cfg_prdata,
  output logic               cfg_pready
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_DONE
  } state_t;

  env_cfg_t           cfg;
  state_t             state_r;
  logic [TICK_W-1:0]  offset_r;
  logic [LEVEL_W-1:0] level_r;
  phase_t             phase_r;
  logic               out_valid_r;
  logic [LEVEL_W-1:0] out_level_r;
  phase_t             out_phase_r;

  logic               accept;
  logic               div_start;
  logic               div_done;
  logic [LEVEL_W-1:0] step;
  logic [TICK_W-1:0]  off_sel;
  logic [TICK_W:0]    hold_end;
  logic [TICK_W+1:0]  rel_end;
  phase_t             phase_sel;
  logic [TICK_W-1:0]  divisor;
  logic [LEVEL_W:0]   sum;
  logic [LEVEL_W-1:0] level_nxt;
  logic               finish;

  lae_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  lae_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (cfg.max_level),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (step)
  );

  assign in_stall  = (state_r != ST_IDLE);
  assign accept    = in_valid & ~in_stall;
  assign div_start = accept;
  assign finish    = (state_r == ST_DONE) & (~out_valid_r | ~out_stall);

  assign off_sel  = in_trigger ? '0 : offset_r;
  assign hold_end = {1'b0, cfg.attack_ticks} + {1'b0, cfg.decay_ticks};
  assign rel_end  = {1'b0, hold_end} + {2'b00, cfg.release_ticks};

  always_comb begin
    if (cfg.attack_ticks == '0 && cfg.decay_ticks == '0 && cfg.release_ticks == '0) begin
      phase_sel = PH_IDLE;
    end else if (off_sel <= cfg.attack_ticks) begin
      phase_sel = PH_ATTACK;
    end else if ({1'b0, off_sel} <= hold_end) begin
      phase_sel = PH_HOLD;
    end else if ({2'b00, off_sel} <= rel_end) begin
      phase_sel = PH_RELEASE;
    end else begin
      phase_sel = PH_IDLE;
    end
  end

  assign divisor = (phase_sel == PH_ATTACK) ? cfg.attack_ticks : cfg.release_ticks;
  assign sum     = {1'b0, level_r} + {1'b0, step};

  always_comb begin
    case (phase_r)
      PH_ATTACK: begin
        if (cfg.attack_ticks == '0 || sum > {1'b0, cfg.max_level}) begin
          level_nxt = cfg.max_level;
        end else begin
          level_nxt = sum[LEVEL_W-1:0];
        end
      end
      PH_HOLD:    level_nxt = cfg.max_level;
      PH_RELEASE: begin
        if (level_r < step || (level_r - step) < cfg.min_level) begin
          level_nxt = cfg.min_level;
        end else begin
          level_nxt = level_r - step;
        end
      end
      default:    level_nxt = cfg.min_level;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      offset_r    <= '0;
      level_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (finish) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
      unique case (state_r)
        ST_IDLE: begin
          if (accept) begin
            offset_r <= off_sel;
            phase_r  <= phase_sel;
            state_r  <= ST_DIV;
          end
        end
        ST_DIV: begin
          if (div_done) begin
            state_r <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (finish) begin
            level_r     <= level_nxt;
            out_level_r <= level_nxt;
            out_phase_r <= phase_r;
            if (offset_r < OFFSET_LIMIT) begin
              offset_r <= offset_r + 1'b1;
            end
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_level = out_level_r;
  assign out_phase = out_phase_r;

endmodule

[rtl/lae_cfg.sv]
// ----------------------------------------------------------------------------
// lae_cfg
// apb register file holding envelope lengths and levels
// ----------------------------------------------------------------------------
module lae_cfg
  import lae_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [PDATA_W-1:0] pwdata,
  output logic [PDATA_W-1:0] prdata,
  output logic               pready,
  output env_cfg_t           cfg
);

  env_cfg_t   cfg_r;
  logic [2:0] idx;
  logic       wr_en;

  assign idx    = paddr[4:2];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.attack_ticks  <= '0;
      cfg_r.decay_ticks   <= '0;
      cfg_r.release_ticks <= '0;
      cfg_r.min_level     <= '0;
      cfg_r.max_level     <= MAX_LEVEL_RST;
    end else if (wr_en) begin
      unique case (idx)
        REG_ATTACK:  cfg_r.attack_ticks  <= pwdata[TICK_W-1:0];
        REG_DECAY:   cfg_r.decay_ticks   <= pwdata[TICK_W-1:0];
        REG_RELEASE: cfg_r.release_ticks <= pwdata[TICK_W-1:0];
        REG_MIN:     cfg_r.min_level     <= pwdata[LEVEL_W-1:0];
        REG_MAX:     cfg_r.max_level     <= pwdata[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_ATTACK:  prdata = PDATA_W'(cfg_r.attack_ticks);
      REG_DECAY:   prdata = PDATA_W'(cfg_r.decay_ticks);
      REG_RELEASE: prdata = PDATA_W'(cfg_r.release_ticks);
      REG_MIN:     prdata = PDATA_W'(cfg_r.min_level);
      REG_MAX:     prdata = PDATA_W'(cfg_r.max_level);
      default:     prdata = '0;
    endcase
  end

endmodule

[rtl/lae_div.sv]
// ----------------------------------------------------------------------------
// lae_div
// bit-serial restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module lae_div
  import lae_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [LEVEL_W-1:0] dividend,
  input  logic [TICK_W-1:0]  divisor,
  output logic               done,
  output logic [LEVEL_W-1:0] quotient
);

  localparam int unsigned CNT_W = $clog2(LEVEL_W + 1);

  logic               busy_r;
  logic               done_r;
  logic [CNT_W-1:0]   cnt_r;
  logic [TICK_W-1:0]  rem_r;
  logic [LEVEL_W-1:0] dvd_r;
  logic [TICK_W-1:0]  dvs_r;

  logic [TICK_W:0]    trial;
  logic [TICK_W:0]    diff;
  logic               ge;

  assign trial    = {rem_r, dvd_r[LEVEL_W-1]};
  assign ge       = trial >= {1'b0, dvs_r};
  assign diff     = trial - {1'b0, dvs_r};
  assign done     = done_r;
  assign quotient = dvd_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 1'b1;
        if (cnt_r == CNT_W'(LEVEL_W - 1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      dvs_r <= divisor;
    end else if (busy_r) begin
      rem_r <= ge ? diff[TICK_W-1:0] : trial[TICK_W-1:0];
      dvd_r <= {dvd_r[LEVEL_W-2:0], ge};
    end
  end

endmodule

[rtl/lae_checker.sv]
// ----------------------------------------------------------------------------
// lae_checker
// port-level checks of the led envelope generator, bound to the top level
// ----------------------------------------------------------------------------
module lae_checker
  import lae_pkg::*;
(
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic [LEVEL_W-1:0] out_level,
  input logic [1:0]         out_phase
);

  logic in_acc;
  assign in_acc = in_valid & ~in_stall;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_level) && $stable(out_phase))
    else $error("stalled result changed");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("input not stalled after item accepted");

  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result appeared without an item in flight");

  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !$past(in_acc))
    else $error("two items accepted in consecutive cycles");

endmodule

bind led_adsr_envelope lae_checker u_lae_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_level (out_level),
  .out_phase (out_phase)
);
